@@ hdl/tcm_pkg.sv @@
package tcm_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int OUT_PAGE_W = 20;

   // operations carried by req_op
   typedef enum logic [2:0] {
      OP_LOOKUP        = 3'd0,
      OP_FILL          = 3'd1,
      OP_FLUSH_PAGE    = 3'd2,
      OP_FLUSH_PAGE_NG = 3'd3,
      OP_FLUSH_ALL     = 3'd4,
      OP_FLUSH_ALL_NG  = 3'd5
   } op_type;

   // register slots, byte address 4*index
   typedef enum logic [2:0] {
      REG_ITT_FIRST  = 3'd0,
      REG_ITT_SECOND = 3'd1,
      REG_DTT_FIRST  = 3'd2,
      REG_DTT_SECOND = 3'd3,
      REG_TRANS_EN   = 3'd4,
      REG_DEST_FC    = 3'd5
   } reg_index_type;

   // descriptor bits
   localparam int DSC_W_BIT = 2;
   localparam int DSC_M_BIT = 4;
   localparam int DSC_S_BIT = 7;
   localparam int DSC_G_BIT = 10;

   // transparent window bits
   localparam int TT_W_BIT = 2;
   localparam int TT_E_BIT = 15;

   // window space field codes
   localparam logic [1:0] TT_S_USER  = 2'd0;
   localparam logic [1:0] TT_S_SUPER = 2'd1;

   // window match outcomes
   localparam logic [1:0] TT_MISS   = 2'd0;
   localparam logic [1:0] TT_HIT    = 2'd1;
   localparam logic [1:0] TT_HIT_WP = 2'd3;

   // function codes that let flushes reach the user banks
   localparam logic [2:0] FC_USER_DATA = 3'd1;
   localparam logic [2:0] FC_USER_CODE = 3'd2;

   typedef struct packed {
      logic [31:0] itt_first;
      logic [31:0] itt_second;
      logic [31:0] dtt_first;
      logic [31:0] dtt_second;
      logic        translation_enable;
      logic [2:0]  dest_function_code;
   } cfg_type;

   typedef struct packed {
      logic                  needs_walk;
      logic                  resident;
      logic                  transparent;
      logic [OUT_PAGE_W-1:0] phys_page;
      logic                  write_protected;
      logic                  modified;
      logic [1:0]            cache_mode;
      logic                  super_only;
      logic [1:0]            user_bits;
      logic                  global_page;
      logic                  set_modified;
   } rsp_type;

   function automatic logic [1:0] tt_match(logic [31:0] w, logic [7:0] top, logic sup);
      logic [1:0] s;
      logic [7:0] msk;
      logic [1:0] r;
      s   = w[14:13];
      msk = w[23:16];
      r   = TT_MISS;
      if (w[TT_E_BIT] && !((s == TT_S_USER && sup) || (s == TT_S_SUPER && !sup)) &&
          ((top & ~msk) == (w[31:24] & ~msk))) begin
         r = w[TT_W_BIT] ? TT_HIT_WP : TT_HIT;
      end
      return r;
   endfunction

   function automatic logic [OUT_PAGE_W-1:0] low_page(logic [31:0] w);
      return w[OUT_PAGE_W-1:0];
   endfunction

endpackage

@@ hdl/translation_cache_with_transparent_match.sv @@
// channel   direction  handshake             payload
// req       in         req_valid/req_ready   op, logical_page, supervisor, code_space,
//                                            write_access, page_descriptor,
//                                            upper_write_protect
// rsp       out        rsp_valid/rsp_ready   needs_walk .. set_modified, one per transaction
// csr       in         psel/penable/pwrite   apb registers at 4*index, pready tied high
//
// one transaction per cycle sustained while rsp is not stalled; the result is registered
// (accept loads the stage register and the bank ram read, the stage advancing loads the result)
// the rate is set by the single stage between the ram read and the result register
// reset is synchronous: every valid bit, the pipeline and the registers clear at once
// a stalled rsp holds the stage register, and req_ready drops only while both are full
module translation_cache_with_transparent_match
   import tcm_pkg::*;
#(
   parameter int ENTRIES_PER_BANK = 16,
   parameter int PAGE_BITS        = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_op,
   input  logic [PAGE_BITS-1:0]  req_logical_page,
   input  logic                  req_supervisor,
   input  logic                  req_code_space,
   input  logic                  req_write_access,
   input  logic [31:0]           req_page_descriptor,
   input  logic                  req_upper_write_protect,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_needs_walk,
   output logic                  rsp_resident,
   output logic                  rsp_transparent,
   output logic [19:0]           rsp_phys_page,
   output logic                  rsp_write_protected,
   output logic                  rsp_modified,
   output logic [1:0]            rsp_cache_mode,
   output logic                  rsp_super_only,
   output logic [1:0]            rsp_user_bits,
   output logic                  rsp_global_page,
   output logic                  rsp_set_modified,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IDX_W  = $clog2(ENTRIES_PER_BANK);
   localparam int BANKS  = 4;

   // one cached translation, kept in the bank rams
   typedef struct packed {
      logic                 res;
      logic [PAGE_BITS-1:0] tag;
      logic [PAGE_BITS-1:0] phys;
      logic                 sup;
      logic                 mod;
      logic                 wp;
      logic [1:0]           cm;
      logic [1:0]           ub;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   cfg_type cfg;

   // handshake control
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, advance;

   // stage register, payload
   op_type               op_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic                 sup_ff, code_ff, wr_ff, uwp_ff;
   logic [31:0]          dsc_ff;
   logic [IDX_W-1:0]     idx_ff;

   logic [IDX_W-1:0]     idx_next;
   logic [1:0]           bank;

   // per-entry valid and global flags live in flops so a bulk flush can clear every entry at once
   logic [BANKS-1:0][ENTRIES_PER_BANK-1:0] valid_ff, valid_in;
   logic [BANKS-1:0][ENTRIES_PER_BANK-1:0] glob_ff, glob_in;

   // bank rams and the forwarding path for a write retiring on the read edge
   logic [BANKS-1:0][ENTRY_W-1:0] ram_rd;
   logic [BANKS-1:0]              ram_we;
   logic [BANKS-1:0]              byp_hit_ff, byp_hit_in;
   entry_type                     byp_data_ff;
   entry_type                     ent [BANKS];
   entry_type                     wr_data;
   logic                          wr_en;

   rsp_type rsp_ff, rsp_in;

   tcm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tcm_index #(
      .ENTRIES   (ENTRIES_PER_BANK),
      .PAGE_BITS (PAGE_BITS)
   ) u_index (
      .page (req_logical_page),
      .idx  (idx_next)
   );

   for (genvar gb = 0; gb < BANKS; gb++) begin : g_bank
      tcm_ram #(
         .WIDTH (ENTRY_W),
         .DEPTH (ENTRIES_PER_BANK)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we[gb]),
         .wr_addr (idx_ff),
         .wr_data (wr_data),
         .rd_en   (accept),
         .rd_addr (idx_next),
         .rd_data (ram_rd[gb])
      );
      assign ram_we[gb]     = advance && wr_en && (bank == 2'(gb));
      assign byp_hit_in[gb] = advance && wr_en && (bank == 2'(gb)) && (idx_ff == idx_next);
      assign ent[gb]        = byp_hit_ff[gb] ? byp_data_ff : entry_type'(ram_rd[gb]);
   end

   // pipeline handshake
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || advance;
   assign accept       = req_valid && req_ready;
   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // bank order: user data, user code, supervisor data, supervisor code
   assign bank = {sup_ff, code_ff};

   function automatic rsp_type report_entry(entry_type e, logic g);
      rsp_type r;
      r = '0;
      if (e.res) begin
         r.resident        = 1'b1;
         r.phys_page       = low_page(32'(e.phys));
         r.write_protected = e.wp;
         r.modified        = e.mod;
         r.cache_mode      = e.cm;
         r.super_only      = e.sup;
         r.user_bits       = e.ub;
         r.global_page     = g;
      end
      return r;
   endfunction

   // single stage: windows, pass-through, bank probe, fill and flushes
   always_comb begin
      logic [1:0] m1, m2, m;
      logic       user_ok, ng, hit, setmod, wp, sp, md, g;
      entry_type  sel_e, upd;
      logic [7:0] top;

      rsp_in   = '0;
      wr_en    = 1'b0;
      valid_in = valid_ff;
      glob_in  = glob_ff;
      sel_e    = ent[bank];
      upd      = sel_e;
      top      = page_ff[PAGE_BITS-1 -: 8];
      user_ok  = (cfg.dest_function_code == FC_USER_DATA) ||
                 (cfg.dest_function_code == FC_USER_CODE);
      ng       = op_ff inside {OP_FLUSH_PAGE_NG, OP_FLUSH_ALL_NG};
      m1       = tt_match(code_ff ? cfg.itt_first : cfg.dtt_first, top, sup_ff);
      m2       = tt_match(code_ff ? cfg.itt_second : cfg.dtt_second, top, sup_ff);
      m        = (m1 != TT_MISS) ? m1 : m2;
      hit      = valid_ff[bank][idx_ff] && (sel_e.tag == page_ff);
      setmod   = 1'b0;
      wp       = uwp_ff || dsc_ff[DSC_W_BIT];
      sp       = dsc_ff[DSC_S_BIT];
      md       = dsc_ff[DSC_M_BIT];
      g        = 1'b0;

      case (op_ff)
         OP_LOOKUP: begin
            if (m != TT_MISS) begin
               // a write into a protected window reports not resident
               if (!(m == TT_HIT_WP && wr_ff)) begin
                  rsp_in.resident        = 1'b1;
                  rsp_in.transparent     = 1'b1;
                  rsp_in.phys_page       = low_page(32'(page_ff));
                  rsp_in.write_protected = (m == TT_HIT_WP);
               end
            end else if (!cfg.translation_enable) begin
               rsp_in.resident  = 1'b1;
               rsp_in.phys_page = low_page(32'(page_ff));
            end else if (!hit) begin
               rsp_in.needs_walk = 1'b1;
            end else begin
               // first write to a writable page marks it modified
               setmod = sel_e.res && wr_ff && !sel_e.wp && !sel_e.mod &&
                        !(sel_e.sup && !sup_ff);
               if (setmod) begin
                  upd.mod = 1'b1;
                  wr_en   = 1'b1;
               end
               rsp_in              = report_entry(upd, glob_ff[bank][idx_ff]);
               rsp_in.set_modified = setmod;
            end
         end
         OP_FILL: begin
            upd     = '0;
            upd.tag = page_ff;
            if (dsc_ff[1:0] != 2'd0) begin
               if (!(wp && wr_ff) && !(sp && !sup_ff) && !md && wr_ff) begin
                  md     = 1'b1;
                  setmod = 1'b1;
               end
               upd.res  = 1'b1;
               upd.phys = dsc_ff[31 -: PAGE_BITS];
               upd.ub   = dsc_ff[9:8];
               upd.sup  = sp;
               upd.cm   = dsc_ff[6:5];
               upd.mod  = md;
               upd.wp   = wp;
               g        = dsc_ff[DSC_G_BIT];
            end
            wr_en                   = 1'b1;
            valid_in[bank][idx_ff]  = 1'b1;
            glob_in[bank][idx_ff]   = g;
            rsp_in                  = report_entry(upd, g);
            rsp_in.set_modified     = setmod;
         end
         OP_FLUSH_PAGE, OP_FLUSH_PAGE_NG: begin
            for (int b = 0; b < BANKS; b++) begin
               if ((b >= 2 || user_ok) && (ent[b].tag == page_ff) &&
                   !(ng && glob_ff[b][idx_ff])) begin
                  valid_in[b][idx_ff] = 1'b0;
               end
            end
         end
         OP_FLUSH_ALL, OP_FLUSH_ALL_NG: begin
            for (int b = 0; b < BANKS; b++) begin
               for (int i = 0; i < ENTRIES_PER_BANK; i++) begin
                  if ((b >= 2 || user_ok) && !(ng && glob_ff[b][i])) begin
                     valid_in[b][i] = 1'b0;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      wr_data = upd;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_hit_ff   <= '0;
         valid_ff     <= '0;
         glob_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            byp_hit_ff <= byp_hit_in;
         end
         if (advance) begin
            valid_ff <= valid_in;
            glob_ff  <= glob_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= op_type'(req_op);
         page_ff     <= req_logical_page;
         sup_ff      <= req_supervisor;
         code_ff     <= req_code_space;
         wr_ff       <= req_write_access;
         dsc_ff      <= req_page_descriptor;
         uwp_ff      <= req_upper_write_protect;
         idx_ff      <= idx_next;
         byp_data_ff <= wr_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_needs_walk      = rsp_ff.needs_walk;
   assign rsp_resident        = rsp_ff.resident;
   assign rsp_transparent     = rsp_ff.transparent;
   assign rsp_phys_page       = rsp_ff.phys_page;
   assign rsp_write_protected = rsp_ff.write_protected;
   assign rsp_modified        = rsp_ff.modified;
   assign rsp_cache_mode      = rsp_ff.cache_mode;
   assign rsp_super_only      = rsp_ff.super_only;
   assign rsp_user_bits       = rsp_ff.user_bits;
   assign rsp_global_page     = rsp_ff.global_page;
   assign rsp_set_modified    = rsp_ff.set_modified;

`ifndef SYNTHESIS
   // a full stage behind a stalled result must stop new transactions
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("transaction accepted while both stages are stalled");

   // a global flush that reaches every bank leaves nothing valid
   a_flush_all_clears: assert property (@(posedge clock) disable iff (reset)
      advance && op_ff == OP_FLUSH_ALL &&
      (cfg.dest_function_code == FC_USER_DATA || cfg.dest_function_code == FC_USER_CODE)
      |=> valid_ff == '0)
      else $error("flush all left valid entries");

   // a modify request always comes with a resident, modified result
   a_setmod_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.set_modified |-> rsp_ff.modified && rsp_ff.resident)
      else $error("set_modified without a resident modified page");

   // forwarding only ever targets the one bank being written
   a_bypass_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(byp_hit_ff))
      else $error("forwarding hit in more than one bank");
`endif

endmodule

@@ hdl/tcm_ram.sv @@
module tcm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tcm_index.sv @@
module tcm_index #(
   parameter int ENTRIES   = 16,
   parameter int PAGE_BITS = 20
) (
   input  logic [PAGE_BITS-1:0]       page,
   output logic [$clog2(ENTRIES)-1:0] idx
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int ACC_W  = IDX_W + 1;
   localparam int CHUNKS = (PAGE_BITS + 7) / 8;
   localparam int PAD_W  = CHUNKS * 8;

   logic [PAD_W-1:0] page_pad;
   logic [IDX_W-1:0] part_tbl [CHUNKS][256];

   assign page_pad = PAD_W'(page);

   // residue of each byte value at each byte position
   for (genvar gi = 0; gi < CHUNKS; gi++) begin : g_chunk
      for (genvar gc = 0; gc < 256; gc++) begin : g_val
         localparam int WEIGHT = (2 ** (8 * gi)) % ENTRIES;
         localparam int RESID  = (gc * WEIGHT) % ENTRIES;
         assign part_tbl[gi][gc] = IDX_W'(RESID);
      end
   end

   // sum the byte residues, folding back below the bank size each step
   always_comb begin
      logic [ACC_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < CHUNKS; i++) begin
         acc = acc + ACC_W'(part_tbl[i][page_pad[8*i +: 8]]);
         if (acc >= ACC_W'(ENTRIES)) begin
            acc = acc - ACC_W'(ENTRIES);
         end
      end
      idx = acc[IDX_W-1:0];
   end

endmodule

@@ hdl/tcm_csr.sv @@
module tcm_csr
   import tcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   reg_index_type sel;
   logic          wr_stb;

   assign sel    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_stb = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_stb) begin
         case (sel)
            REG_ITT_FIRST:  cfg_ff.itt_first          <= pwdata;
            REG_ITT_SECOND: cfg_ff.itt_second         <= pwdata;
            REG_DTT_FIRST:  cfg_ff.dtt_first          <= pwdata;
            REG_DTT_SECOND: cfg_ff.dtt_second         <= pwdata;
            REG_TRANS_EN:   cfg_ff.translation_enable <= pwdata[0];
            REG_DEST_FC:    cfg_ff.dest_function_code <= pwdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_ITT_FIRST:  prdata = cfg_ff.itt_first;
         REG_ITT_SECOND: prdata = cfg_ff.itt_second;
         REG_DTT_FIRST:  prdata = cfg_ff.dtt_first;
         REG_DTT_SECOND: prdata = cfg_ff.dtt_second;
         REG_TRANS_EN:   prdata = {31'd0, cfg_ff.translation_enable};
         REG_DEST_FC:    prdata = {29'd0, cfg_ff.dest_function_code};
         default:        prdata = '0;
      endcase
   end

endmodule

@@ tb/translation_cache_with_transparent_match_tb.sv @@
module translation_cache_with_transparent_match_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcm_pkg::*;

   localparam int SLOTS       = 16;     // entries per bank
   localparam int PAGE_W      = 20;
   localparam int POOL_SIZE   = 24;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 131;
   localparam int QUIET_LIMIT = 4000;   // cycles with no transaction at all

   // op codes the block has no name for, must change nothing
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   // window space field: both user and supervisor
   localparam logic [1:0] TT_S_BOTH = 2'd2;

   // descriptor type field
   localparam logic [1:0] DSC_INVALID    = 2'd0;
   localparam logic [1:0] DSC_RESIDENT_A = 2'd1;
   localparam logic [1:0] DSC_RESIDENT_B = 2'd2;
   localparam logic [1:0] DSC_RESIDENT_C = 2'd3;

   typedef struct packed {
      logic [2:0]        op;
      logic [PAGE_W-1:0] page;
      logic              sup;
      logic              code;
      logic              wr;
      logic [31:0]       desc;
      logic              uwp;
   } xlat_req_type;

   // one cached translation
   typedef struct packed {
      logic              valid;
      logic              res;
      logic              glob;
      logic              sup;
      logic              mod;
      logic              wp;
      logic [PAGE_W-1:0] tag;
      logic [PAGE_W-1:0] phys;
      logic [1:0]        cm;
      logic [1:0]        ub;
   } tlb_line_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [2:0]        req_op = '0;
   logic [PAGE_W-1:0] req_logical_page = '0;
   logic              req_supervisor = 1'b0;
   logic              req_code_space = 1'b0;
   logic              req_write_access = 1'b0;
   logic [31:0]       req_page_descriptor = '0;
   logic              req_upper_write_protect = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_needs_walk;
   logic        rsp_resident;
   logic        rsp_transparent;
   logic [19:0] rsp_phys_page;
   logic        rsp_write_protected;
   logic        rsp_modified;
   logic [1:0]  rsp_cache_mode;
   logic        rsp_super_only;
   logic [1:0]  rsp_user_bits;
   logic        rsp_global_page;
   logic        rsp_set_modified;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // shadow of the register file, updated as each write lands
   logic [31:0] window_reg [4];
   logic        xlate_on = 1'b0;
   logic [2:0]  flush_fc = '0;

   // shadow of the four banks: {supervisor, code} picks the bank
   tlb_line_type tlb_shadow [4][SLOTS];

   xlat_req_type pending_reqs [$];     // stimulus not yet driven
   rsp_type      translation_due [$];  // predicted results, oldest first

   xlat_req_type next_req;
   xlat_req_type seen;
   rsp_type     got;
   rsp_type     want;
   int          queued_count = 0;
   int          taken_count = 0;
   int          driven_count = 0;
   int          fail_count = 0;
   int          quiet_cycles = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   logic [7:0]  top_pool [4];
   logic [19:0] page_pool [POOL_SIZE];

   translation_cache_with_transparent_match DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_op                  (req_op),
      .req_logical_page        (req_logical_page),
      .req_supervisor          (req_supervisor),
      .req_code_space          (req_code_space),
      .req_write_access        (req_write_access),
      .req_page_descriptor     (req_page_descriptor),
      .req_upper_write_protect (req_upper_write_protect),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_needs_walk          (rsp_needs_walk),
      .rsp_resident            (rsp_resident),
      .rsp_transparent         (rsp_transparent),
      .rsp_phys_page           (rsp_phys_page),
      .rsp_write_protected     (rsp_write_protected),
      .rsp_modified            (rsp_modified),
      .rsp_cache_mode          (rsp_cache_mode),
      .rsp_super_only          (rsp_super_only),
      .rsp_user_bits           (rsp_user_bits),
      .rsp_global_page         (rsp_global_page),
      .rsp_set_modified        (rsp_set_modified),
      .psel                    (psel),
      .penable                 (penable),
      .pwrite                  (pwrite),
      .paddr                   (paddr),
      .pwdata                  (pwdata),
      .prdata                  (prdata),
      .pready                  (pready)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // shadow model of the translation cache
   // ------------------------------------------------------------------

   // transparent window check for one window register
   function automatic logic [1:0] window_hit(logic [31:0] w, logic [PAGE_W-1:0] page,
                                             logic sup);
      logic [7:0] top;
      logic [7:0] msk;
      top = page[PAGE_W-1 -: 8];
      msk = w[23:16];
      if (!w[TT_E_BIT])
         return TT_MISS;
      if ((w[14:13] == TT_S_USER && sup) || (w[14:13] == TT_S_SUPER && !sup))
         return TT_MISS;
      if ((top & ~msk) != (w[31:24] & ~msk))
         return TT_MISS;
      return w[TT_W_BIT] ? TT_HIT_WP : TT_HIT;
   endfunction

   // attributes of a cached line; a non-resident line reports nothing
   function automatic rsp_type line_report(tlb_line_type ln);
      rsp_type r;
      r = '0;
      if (ln.res) begin
         r.resident        = 1'b1;
         r.phys_page       = ln.phys;
         r.write_protected = ln.wp;
         r.modified        = ln.mod;
         r.cache_mode      = ln.cm;
         r.super_only      = ln.sup;
         r.user_bits       = ln.ub;
         r.global_page     = ln.glob;
      end
      return r;
   endfunction

   // invalidate by page or in bulk; user banks only for user function codes
   function automatic void flush_lines(logic [PAGE_W-1:0] page, logic all, logic ng);
      logic user_ok;
      user_ok = (flush_fc == FC_USER_DATA) || (flush_fc == FC_USER_CODE);
      for (int b = 0; b < 4; b++) begin
         if (b >= 2 || user_ok) begin
            for (int i = 0; i < SLOTS; i++) begin
               if ((all || (i == page % SLOTS && tlb_shadow[b][i].tag == page)) &&
                   !(ng && tlb_shadow[b][i].glob))
                  tlb_shadow[b][i].valid = 1'b0;
            end
         end
      end
   endfunction

   // expected result of one transaction, updating the shadow banks
   function automatic rsp_type translate_request(xlat_req_type t);
      rsp_type      r;
      tlb_line_type ln;
      logic [1:0]   hit;
      int           bank;
      int           slot;
      logic         wp;
      logic         md;
      r    = '0;
      bank = int'({t.sup, t.code});
      slot = t.page % SLOTS;
      case (t.op)
         OP_LOOKUP: begin
            hit = window_hit(window_reg[2'(t.code ? REG_ITT_FIRST : REG_DTT_FIRST)],
                             t.page, t.sup);
            if (hit == TT_MISS)
               hit = window_hit(window_reg[2'(t.code ? REG_ITT_SECOND : REG_DTT_SECOND)],
                                t.page, t.sup);
            if (hit != TT_MISS) begin
               // a write into a protected window reports not resident
               if (!(hit == TT_HIT_WP && t.wr)) begin
                  r.resident        = 1'b1;
                  r.transparent     = 1'b1;
                  r.phys_page       = t.page;
                  r.write_protected = (hit == TT_HIT_WP);
               end
            end else if (!xlate_on) begin
               r.resident  = 1'b1;
               r.phys_page = t.page;
            end else if (!tlb_shadow[bank][slot].valid ||
                         tlb_shadow[bank][slot].tag != t.page) begin
               r.needs_walk = 1'b1;
            end else begin
               ln = tlb_shadow[bank][slot];
               // first permitted write to a clean page marks it dirty
               if (ln.res && t.wr && !ln.wp && !ln.mod && !(ln.sup && !t.sup)) begin
                  ln.mod = 1'b1;
                  tlb_shadow[bank][slot] = ln;
                  r = line_report(ln);
                  r.set_modified = 1'b1;
               end else begin
                  r = line_report(ln);
               end
            end
         end
         OP_FILL: begin
            ln       = '0;
            ln.valid = 1'b1;
            ln.tag   = t.page;
            if (t.desc[1:0] != DSC_INVALID) begin
               wp = t.uwp | t.desc[DSC_W_BIT];
               md = t.desc[DSC_M_BIT];
               if (!(wp && t.wr) && !(t.desc[DSC_S_BIT] && !t.sup) && !md && t.wr) begin
                  md = 1'b1;
                  r.set_modified = 1'b1;
               end
               ln.res  = 1'b1;
               ln.glob = t.desc[DSC_G_BIT];
               ln.phys = t.desc[31 -: PAGE_W];
               ln.ub   = t.desc[9:8];
               ln.sup  = t.desc[DSC_S_BIT];
               ln.cm   = t.desc[6:5];
               ln.mod  = md;
               ln.wp   = wp;
            end
            tlb_shadow[bank][slot] = ln;
            r = line_report(ln) | r;
         end
         OP_FLUSH_PAGE:    flush_lines(t.page, 1'b0, 1'b0);
         OP_FLUSH_PAGE_NG: flush_lines(t.page, 1'b0, 1'b1);
         OP_FLUSH_ALL:     flush_lines(t.page, 1'b1, 1'b0);
         OP_FLUSH_ALL_NG:  flush_lines(t.page, 1'b1, 1'b1);
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // checking helpers
   // ------------------------------------------------------------------

   function automatic bit field_differs(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // bitwise or so every bad field gets its own report
   function automatic bit rsp_differs(rsp_type e, rsp_type a);
      return field_differs("needs_walk", 32'(e.needs_walk), 32'(a.needs_walk)) |
             field_differs("resident", 32'(e.resident), 32'(a.resident)) |
             field_differs("transparent", 32'(e.transparent), 32'(a.transparent)) |
             field_differs("phys_page", 32'(e.phys_page), 32'(a.phys_page)) |
             field_differs("write_protected", 32'(e.write_protected),
                           32'(a.write_protected)) |
             field_differs("modified", 32'(e.modified), 32'(a.modified)) |
             field_differs("cache_mode", 32'(e.cache_mode), 32'(a.cache_mode)) |
             field_differs("super_only", 32'(e.super_only), 32'(a.super_only)) |
             field_differs("user_bits", 32'(e.user_bits), 32'(a.user_bits)) |
             field_differs("global_page", 32'(e.global_page), 32'(a.global_page)) |
             field_differs("set_modified", 32'(e.set_modified), 32'(a.set_modified));
   endfunction

   // ------------------------------------------------------------------
   // request driver: falling edge, holds a transaction until accepted
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         // free to move on when nothing is held or the held one was taken
         if (!req_valid || taken_count != driven_count) begin
            driven_count = taken_count;
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
               next_req = pending_reqs.pop_front();
               req_valid               <= 1'b1;
               req_op                  <= next_req.op;
               req_logical_page        <= next_req.page;
               req_supervisor          <= next_req.sup;
               req_code_space          <= next_req.code;
               req_write_access        <= next_req.wr;
               req_page_descriptor     <= next_req.desc;
               req_upper_write_protect <= next_req.uwp;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: rising edge, predicts on acceptance and checks results
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            // predict from what the block actually saw on its ports
            seen.op   = req_op;
            seen.page = req_logical_page;
            seen.sup  = req_supervisor;
            seen.code = req_code_space;
            seen.wr   = req_write_access;
            seen.desc = req_page_descriptor;
            seen.uwp  = req_upper_write_protect;
            translation_due.push_back(translate_request(seen));
            taken_count++;
         end
         if (rsp_valid && rsp_ready) begin
            got.needs_walk      = rsp_needs_walk;
            got.resident        = rsp_resident;
            got.transparent     = rsp_transparent;
            got.phys_page       = rsp_phys_page;
            got.write_protected = rsp_write_protected;
            got.modified        = rsp_modified;
            got.cache_mode      = rsp_cache_mode;
            got.super_only      = rsp_super_only;
            got.user_bits       = rsp_user_bits;
            got.global_page     = rsp_global_page;
            got.set_modified    = rsp_set_modified;
            if (translation_due.size() == 0) begin
               $error("result transaction with no request outstanding");
               fail_count++;
            end else begin
               want = translation_due.pop_front();
               if (rsp_differs(want, got))
                  fail_count++;
            end
         end
      end
   end

   // watchdog: any transaction on any port counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** translation_cache_with_transparent_match: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic void add_request(logic [2:0] op, logic [PAGE_W-1:0] page, logic sup,
                                       logic code, logic wr, logic [31:0] desc, logic uwp);
      xlat_req_type t;
      t = '{op: op, page: page, sup: sup, code: code, wr: wr, desc: desc, uwp: uwp};
      pending_reqs.push_back(t);
      queued_count++;
   endfunction

   function automatic logic [31:0] window_word(logic [7:0] base, logic [7:0] msk, logic en,
                                               logic [1:0] space, logic [1:0] ub,
                                               logic [1:0] cm, logic wp);
      return {base, msk, en, space, 3'b000, ub, 1'b0, cm, 2'b00, wp, 2'b00};
   endfunction

   function automatic logic [31:0] desc_word(logic [19:0] phys, logic g, logic [1:0] ub,
                                             logic s, logic [1:0] cm, logic m, logic w,
                                             logic [1:0] kind);
      return {phys, 1'b0, g, ub, s, cm, m, 1'b0, w, kind};
   endfunction

   // windows aimed mostly at the page pool so they actually match
   function automatic logic [31:0] random_window();
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(3) != 0)
         w[31:24] = top_pool[$urandom_range(3)];
      case ($urandom_range(3))
         0: w[23:16] = 8'h00;
         1: w[23:16] = 8'h0F & 8'($urandom);
         default: ;
      endcase
      w[TT_E_BIT] = ($urandom_range(9) < 7);
      return w;
   endfunction

   // register writes: setup cycle then access cycle
   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      case (idx)
         REG_TRANS_EN: xlate_on = value[0];
         REG_DEST_FC:  flush_fc = value[2:0];
         default:      window_reg[2'(idx)] = value;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                            logic [31:0] w3, logic te, logic [2:0] fc);
      write_reg(REG_ITT_FIRST, w0);
      write_reg(REG_ITT_SECOND, w1);
      write_reg(REG_DTT_FIRST, w2);
      write_reg(REG_DTT_SECOND, w3);
      write_reg(REG_TRANS_EN, {31'b0, te});
      write_reg(REG_DEST_FC, {29'b0, fc});
   endtask

   // block is idle once every request is taken and every result is back;
   // the extra wait after that covers the two-stage pipeline
   task automatic wait_drained();
      while (taken_count != queued_count || translation_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      int          roll;
      logic [2:0]  op;
      logic [19:0] page;
      logic [31:0] w [4];

      for (int k = 0; k < 4; k++)
         window_reg[k] = '0;
      for (int b = 0; b < 4; b++)
         for (int i = 0; i < SLOTS; i++)
            tlb_shadow[b][i] = '0;

      // small page pool so that lookups hit and slots alias
      top_pool[0] = 8'h00;
      top_pool[1] = 8'hFF;
      top_pool[2] = 8'($urandom);
      top_pool[3] = 8'($urandom);
      for (int i = 0; i < POOL_SIZE; i++)
         page_pool[i] = {top_pool[i % 4], 8'($urandom), 4'($urandom)};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: translation off, pages pass straight through
      @(posedge clock);
      add_request(OP_LOOKUP, 20'h00000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0);
      add_request(OP_LOOKUP, 20'hFFFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
      wait_drained();

      // directed part: one window per kind of match, translation on
      configure(window_word(8'hA5, 8'h00, 1'b1, TT_S_BOTH, 2'd3, 2'd3, 1'b0),
                window_word(8'h3C, 8'h0F, 1'b1, TT_S_SUPER, 2'd0, 2'd0, 1'b1),
                window_word(8'hFF, 8'h00, 1'b0, TT_S_BOTH, 2'd0, 2'd0, 1'b0),
                window_word(8'h80, 8'h7F, 1'b1, TT_S_USER, 2'd0, 2'd0, 1'b0),
                1'b1, FC_USER_DATA);
      @(posedge clock);
      // miss, then fill with a write to a clean page
      add_request(OP_LOOKUP, 20'h12345, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0);
      add_request(OP_FILL, 20'h12345, 1'b1, 1'b0, 1'b1,
                  desc_word(20'hFFFFF, 1'b1, 2'd3, 1'b1, 2'd3, 1'b0, 1'b0, DSC_RESIDENT_A),
                  1'b0);
      add_request(OP_LOOKUP, 20'h12345, 1'b1, 1'b0, 1'b1, 32'h0, 1'b0);
      // invalid descriptor type leaves a valid, non-resident line
      add_request(OP_FILL, 20'h00005, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFC, 1'b1);
      add_request(OP_LOOKUP, 20'h00005, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0);
      // supervisor-only page touched by a user write
      add_request(OP_FILL, 20'h00007, 1'b0, 1'b0, 1'b1,
                  desc_word(20'h00ABC, 1'b0, 2'd0, 1'b1, 2'd0, 1'b0, 1'b0, DSC_RESIDENT_B),
                  1'b0);
      add_request(OP_LOOKUP, 20'h00007, 1'b0, 1'b0, 1'b1, 32'h0, 1'b0);
      // protection inherited from the upper table levels
      add_request(OP_FILL, 20'h00008, 1'b0, 1'b0, 1'b1,
                  desc_word(20'h11111, 1'b0, 2'd1, 1'b0, 2'd1, 1'b0, 1'b0, DSC_RESIDENT_C),
                  1'b1);
      add_request(OP_LOOKUP, 20'h00008, 1'b0, 1'b0, 1'b1, 32'h0, 1'b0);
      // clean page read-filled, then dirtied by a later write
      add_request(OP_FILL, 20'h00009, 1'b0, 1'b0, 1'b0,
                  desc_word(20'h22222, 1'b0, 2'd2, 1'b0, 2'd2, 1'b0, 1'b0, DSC_RESIDENT_A),
                  1'b0);
      add_request(OP_LOOKUP, 20'h00009, 1'b0, 1'b0, 1'b1, 32'h0, 1'b0);
      // same slot, other tag
      add_request(OP_LOOKUP, 20'h00019, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0);
      add_request(OP_FLUSH_PAGE, 20'h12345, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0);
      add_request(OP_LOOKUP, 20'h12345, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0);
      // global page survives nonglobal flushes, not a plain flush all
      add_request(OP_FILL, 20'h00031, 1'b1, 1'b1, 1'b0,
                  desc_word(20'h33333, 1'b1, 2'd0, 1'b0, 2'd0, 1'b1, 1'b0, DSC_RESIDENT_A),
                  1'b0);
      add_request(OP_FLUSH_ALL_NG, 20'h00000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0);
      add_request(OP_LOOKUP, 20'h00031, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0);
      add_request(OP_FLUSH_PAGE_NG, 20'h00031, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0);
      add_request(OP_LOOKUP, 20'h00031, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0);
      add_request(OP_FLUSH_ALL, 20'h00000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0);
      add_request(OP_LOOKUP, 20'h00031, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0);
      add_request(OP_LOOKUP, 20'h00009, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0);
      // transparent windows: open, protected read, protected write, wrong space, data side
      add_request(OP_LOOKUP, 20'hA5123, 1'b0, 1'b1, 1'b1, 32'h0, 1'b0);
      add_request(OP_LOOKUP, 20'h3F123, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0);
      add_request(OP_LOOKUP, 20'h3F123, 1'b1, 1'b1, 1'b1, 32'h0, 1'b0);
      add_request(OP_LOOKUP, 20'h3F123, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0);
      add_request(OP_LOOKUP, 20'h9ABCD, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0);
      // unnamed op codes
      add_request(OP_SPARE_A, 20'h00009, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1);
      add_request(OP_SPARE_B, 20'h00009, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1);
      wait_drained();

      // random phases: each rewrites every register, then mixes traffic
      for (int p = 0; p < PHASES; p++) begin
         for (int k = 0; k < 4; k++)
            w[k] = (p == 0) ? 32'h0 : (p == 2) ? 32'hFFFF_FFFF : random_window();
         case (p)
            0: configure(w[0], w[1], w[2], w[3], 1'b1, 3'd0);
            1: configure(w[0], w[1], w[2], w[3], 1'b1, FC_USER_DATA);
            2: configure(w[0], w[1], w[2], w[3], 1'b1, 3'h7);
            3: configure(w[0], w[1], w[2], w[3], 1'b0, FC_USER_CODE);
            default: configure(w[0], w[1], w[2], w[3], 1'b1, 3'($urandom_range(7)));
         endcase

         // idling: none, sender gaps, receiver stalls, both
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 72; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 72; end
            default: begin idle_pct = 35; stall_pct = 35; end
         endcase

         @(posedge clock);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 55)
               op = OP_LOOKUP;
            else if (roll < 83)
               op = OP_FILL;
            else if (roll < 87)
               op = OP_FLUSH_PAGE;
            else if (roll < 91)
               op = OP_FLUSH_PAGE_NG;
            else if (roll < 93)
               op = OP_FLUSH_ALL;
            else if (roll < 95)
               op = OP_FLUSH_ALL_NG;
            else
               op = roll[0] ? OP_SPARE_A : OP_SPARE_B;
            if ($urandom_range(3) != 0)
               page = page_pool[$urandom_range(POOL_SIZE - 1)];
            else
               page = 20'($urandom);
            add_request(op, page, 1'($urandom), 1'($urandom), 1'($urandom), $urandom,
                        ($urandom_range(3) == 0));
         end
         wait_drained();
      end

      idle_pct  = 0;
      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("** translation_cache_with_transparent_match: PASSED **");
      else
         $display("** translation_cache_with_transparent_match: FAILED **");
      $finish;
   end

endmodule

@@ files.f @@
hdl/tcm_pkg.sv
hdl/tcm_ram.sv
hdl/tcm_index.sv
hdl/tcm_csr.sv
hdl/translation_cache_with_transparent_match.sv
tb/translation_cache_with_transparent_match_tb.sv
